/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* rtl/obf_pkg.sv */
`timescale 1ns / 1ps
package obf_pkg;
    localparam int PI_Q       = 205887;
    localparam int HALF_PI_Q  = 102944;
    localparam int INV_GAIN   = 39797;
    localparam int ATAN_DEPTH = 24;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_PROJ,
        ST_CENTRE,
        ST_DIV,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_point;
        logic cordic_init;
        logic cordic_step;
        logic proj_calc;
        logic accum;
        logic centre_calc;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic first;
        logic cordic_done;
        logic div_done;
    } t_status;

    function automatic logic [16:0] atan_q16(input logic [4:0] i);
        case (i)
            5'd0:  atan_q16 = 17'd51472;
            5'd1:  atan_q16 = 17'd30385;
            5'd2:  atan_q16 = 17'd16055;
            5'd3:  atan_q16 = 17'd8150;
            5'd4:  atan_q16 = 17'd4091;
            5'd5:  atan_q16 = 17'd2047;
            5'd6:  atan_q16 = 17'd1024;
            5'd7:  atan_q16 = 17'd512;
            5'd8:  atan_q16 = 17'd256;
            5'd9:  atan_q16 = 17'd128;
            5'd10: atan_q16 = 17'd64;
            5'd11: atan_q16 = 17'd32;
            5'd12: atan_q16 = 17'd16;
            5'd13: atan_q16 = 17'd8;
            5'd14: atan_q16 = 17'd4;
            5'd15: atan_q16 = 17'd2;
            5'd16: atan_q16 = 17'd1;
            default: atan_q16 = 17'd0;
        endcase
    endfunction
endpackage

/* rtl/oriented_box_fit_core.sv */
`timescale 1ns / 1ps
// Oriented box fit for a cluster of points at a given heading.
// Input: s_axis, one point per transaction; tdata holds point_x, point_y,
// point_z, source_heading from the lowest bit; tlast marks the last point.
// The heading is taken only from the first point of a cluster.
// Output: m_axis, one box per cluster after its last point; tdata holds
// center_x, center_y, center_z, extent_x, extent_y, extent_z, box_heading.
// Sequence: a point is taken in the idle state and then projected; the first point of
// a cluster runs the rotation unit in between, one micro-rotation per cycle.
// After the last point come the centre step, the divider (one quotient bit per
// cycle) and the load of the output register, which holds the box until m_axis_tready.
// Points of the next cluster are still accepted while it waits; the next box
// stalls the input until the register is free.
// Reset clears all bounds and sums and expects a new cluster.
module oriented_box_fit_core #(
    parameter int MAX_POINTS   = 65536,
    parameter int CORDIC_STEPS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [79:0]   s_axis_tdata,  // point_x, point_y, point_z, source_heading
    input  logic          s_axis_tlast,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [143:0]  m_axis_tdata   // center_x, center_y, center_z, extent_x,
                                         // extent_y, extent_z, box_heading
);
    import obf_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    r_valid;
    logic    w_free;
    logic [20:0] w_cx, w_cy, w_ex, w_ey;
    logic [19:0] w_cz, w_ez;
    logic [16:0] w_hd;

    assign w_free = !r_valid || m_axis_tready;

    obf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .i_out_free (w_free),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    obf_dp #(
        .MAX_POINTS   (MAX_POINTS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_point_x        (s_axis_tdata[19:0]),
        .i_point_y        (s_axis_tdata[39:20]),
        .i_point_z        (s_axis_tdata[59:40]),
        .i_source_heading (s_axis_tdata[78:60]),
        .o_status         (w_status),
        .o_center_x       (w_cx),
        .o_center_y       (w_cy),
        .o_center_z       (w_cz),
        .o_extent_x       (w_ex),
        .o_extent_y       (w_ey),
        .o_extent_z       (w_ez),
        .o_box_heading    (w_hd)
    );

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {3'b000, w_hd, w_ez, w_ey, w_ex, w_cz, w_cy, w_cx};
endmodule

/* rtl/obf_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module obf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    input  logic             i_out_free,
    input  obf_pkg::t_status i_status,
    output logic             o_in_ready,
    output obf_pkg::t_cmd    o_cmd
);
    import obf_pkg::*;

    t_state r_state, n_state;
    logic   r_last, n_last;

    // next state
    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_last  = i_in_last;
                    n_state = i_status.first ? ST_CORDIC : ST_PROJ;
                end
            end
            ST_CORDIC: if (i_status.cordic_done) n_state = ST_PROJ;
            ST_PROJ:   n_state = r_last ? ST_CENTRE : ST_IDLE;
            ST_CENTRE: n_state = ST_DIV;
            ST_DIV:    if (i_status.div_done) n_state = ST_OUT;
            ST_OUT:    if (i_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.load_point  = i_in_valid;
                o_cmd.cordic_init = i_in_valid & i_status.first;
            end
            ST_CORDIC: o_cmd.cordic_step = 1'b1;
            ST_PROJ:   begin
                o_cmd.proj_calc = 1'b1;
            end
            ST_CENTRE: begin
                o_cmd.accum       = 1'b1;
                o_cmd.centre_calc = 1'b1;
                o_cmd.div_init    = 1'b1;
            end
            ST_DIV:    o_cmd.div_step = 1'b1;
            ST_OUT:    o_cmd.out_load = i_out_free;
            default:   o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    `ASSERT_IMPLIES(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == ST_IDLE)
    `ASSERT_NEXT(a_cordic_to_proj, i_clk, i_rst_n,
        r_state == ST_CORDIC && i_status.cordic_done, r_state == ST_PROJ)
    `ASSERT_IMPLIES(a_out_only_free, i_clk, i_rst_n, o_cmd.out_load, i_out_free)
endmodule

/* rtl/obf_dp.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module obf_dp #(
    parameter int MAX_POINTS   = 65536,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  obf_pkg::t_cmd      i_cmd,
    input  logic signed [19:0] i_point_x,
    input  logic signed [19:0] i_point_y,
    input  logic signed [19:0] i_point_z,
    input  logic signed [18:0] i_source_heading,
    output obf_pkg::t_status   o_status,
    output logic        [20:0] o_center_x,
    output logic        [20:0] o_center_y,
    output logic        [19:0] o_center_z,
    output logic        [20:0] o_extent_x,
    output logic        [20:0] o_extent_y,
    output logic        [19:0] o_extent_z,
    output logic        [16:0] o_box_heading
);
    import obf_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = 20 + CW;
    localparam int SIW = $clog2(CORDIC_STEPS + 1);

    logic               r_first;
    logic        [16:0] r_heading;
    logic signed [17:0] r_cos, r_sin;
    logic signed [20:0] r_a1min, r_a1max, r_a2min, r_a2max;
    logic signed [19:0] r_hmin, r_hmax;
    logic signed [SW-1:0] r_hsum;
    logic        [CW-1:0] r_cnt;
    logic signed [19:0] r_px, r_py, r_pz;

    // cordic working registers
    logic signed [19:0] r_cx, r_cy;
    logic signed [18:0] r_cz;
    logic [SIW-1:0]     r_ci;

    // centre and division
    logic signed [20:0] r_ctx, r_cty;
    logic        [SW-1:0] r_rem_q;  // dividend/quotient shift register
    logic        [CW:0]   r_rem;
    logic                 r_neg;
    logic [$clog2(SW+1)-1:0] r_dk;

    // heading fold
    logic signed [19:0] w_h, w_t;
    always_comb begin
        w_h = 20'(i_source_heading);
        if (w_h < 0) w_h = w_h + 20'(PI_Q);
        w_t = (w_h > 20'(HALF_PI_Q)) ? 20'(PI_Q) - w_h : 20'(HALF_PI_Q) - w_h;
        if (w_t < 0) w_t = '0;
        else if (w_t > 20'(HALF_PI_Q)) w_t = 20'(HALF_PI_Q);
    end

    // cordic micro-rotation
    logic signed [19:0] w_dx, w_dy;
    logic signed [18:0] w_at;
    assign w_dx = r_cy >>> r_ci;
    assign w_dy = r_cx >>> r_ci;
    assign w_at = 19'(atan_q16(5'(r_ci)));

    function automatic logic signed [17:0] sat18(input logic signed [19:0] v);
        if (v > 20'sd131071) return 18'sd131071;
        if (v < -20'sd131072) return -18'sd131072;
        return v[17:0];
    endfunction

    function automatic logic signed [20:0] sat21(input logic signed [40:0] v);
        if (v > 41'sd1048575) return 21'sd1048575;
        if (v < -41'sd1048576) return -21'sd1048576;
        return v[20:0];
    endfunction

    // projections onto the two rotated axes, combinational products
    logic signed [38:0] w_p1, w_p2;
    logic signed [20:0] w_q1, w_q2;
    assign w_p1 = 39'(r_px * r_cos) + 39'(r_py * r_sin) + 39'sd32768;
    assign w_p2 = 39'(r_py * r_cos) - 39'(r_px * r_sin) + 39'sd32768;
    assign w_q1 = sat21(41'(w_p1 >>> 16));
    assign w_q2 = sat21(41'(w_p2 >>> 16));

    // centre
    logic signed [21:0] w_s1, w_s2;
    logic signed [40:0] w_c1, w_c2;
    assign w_s1 = 22'(r_a1min) + 22'(r_a1max);
    assign w_s2 = 22'(r_a2min) + 22'(r_a2max);
    assign w_c1 = 41'(w_s1 * r_cos) - 41'(w_s2 * r_sin) + 41'sd65536;
    assign w_c2 = 41'(w_s1 * r_sin) + 41'(w_s2 * r_cos) + 41'sd65536;

    // restoring divide of |sum| by count, one bit per cycle
    logic [CW:0]     w_trial;
    logic [CW:0]     w_rsh;
    assign w_rsh   = {r_rem[CW-1:0], r_rem_q[SW-1]};
    assign w_trial = w_rsh - {1'b0, r_cnt};

    logic [SW-1:0] w_abs;
    assign w_abs = r_hsum[SW-1] ? SW'(-r_hsum) : SW'(r_hsum);

    // spans need one bit more than the bounds
    logic signed [21:0] w_ex, w_ey;
    logic signed [20:0] w_ez;
    assign w_ex = 22'(r_a1max) - 22'(r_a1min);
    assign w_ey = 22'(r_a2max) - 22'(r_a2min);
    assign w_ez = 21'(r_hmax) - 21'(r_hmin);

    logic [SW-1:0] w_q;
    assign w_q = r_neg ? SW'(-r_rem_q) : r_rem_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first   <= 1'b1;
            r_heading <= '0;
            r_cos     <= '0;
            r_sin     <= '0;
            r_a1min   <= '0;
            r_a1max   <= '0;
            r_a2min   <= '0;
            r_a2max   <= '0;
            r_hmin    <= '0;
            r_hmax    <= '0;
            r_hsum    <= '0;
            r_cnt     <= '0;
            r_ci      <= '0;
            r_dk      <= '0;
        end else begin
            // latch point
            if (i_cmd.load_point) begin
                r_px <= i_point_x;
                r_py <= i_point_y;
                r_pz <= i_point_z;
            end
            // start rotation at folded heading
            if (i_cmd.cordic_init) begin
                r_heading <= w_t[16:0];
                r_cx      <= 20'(INV_GAIN);
                r_cy      <= '0;
                r_cz      <= 19'(w_t);
                r_ci      <= '0;
            end
            // one micro-rotation per cycle
            if (i_cmd.cordic_step && !o_status.cordic_done) begin
                if (r_cz >= 0) begin
                    r_cx <= r_cx - w_dx;
                    r_cy <= r_cy + w_dy;
                    r_cz <= r_cz - w_at;
                end else begin
                    r_cx <= r_cx + w_dx;
                    r_cy <= r_cy - w_dy;
                    r_cz <= r_cz + w_at;
                end
                r_ci <= r_ci + 1'b1;
            end
            if (i_cmd.cordic_step && o_status.cordic_done) begin
                r_cos <= sat18(r_cx);
                r_sin <= sat18(r_cy);
            end
            // fold the point into the running bounds, height sum and count
            if (i_cmd.proj_calc) begin
                if (r_first) begin
                    r_a1min <= w_q1; r_a1max <= w_q1;
                    r_a2min <= w_q2; r_a2max <= w_q2;
                    r_hmin  <= r_pz; r_hmax  <= r_pz;
                    r_first <= 1'b0;
                end else begin
                    if (w_q1 < r_a1min) r_a1min <= w_q1;
                    if (w_q1 > r_a1max) r_a1max <= w_q1;
                    if (w_q2 < r_a2min) r_a2min <= w_q2;
                    if (w_q2 > r_a2max) r_a2max <= w_q2;
                    if (r_pz < r_hmin) r_hmin <= r_pz;
                    if (r_pz > r_hmax) r_hmax <= r_pz;
                end
                if (r_cnt < CW'(MAX_POINTS)) begin
                    r_hsum <= r_hsum + SW'(r_pz);
                    r_cnt  <= r_cnt + 1'b1;
                end
            end
            // centre and start of division
            if (i_cmd.centre_calc) begin
                r_ctx   <= sat21(w_c1 >>> 17);
                r_cty   <= sat21(w_c2 >>> 17);
                r_rem_q <= w_abs;
                r_rem   <= '0;
                r_neg   <= r_hsum[SW-1];
                r_dk    <= '0;
            end
            if (i_cmd.div_step && !o_status.div_done) begin
                if (!w_trial[CW]) r_rem <= w_trial;
                else              r_rem <= w_rsh;
                r_rem_q <= {r_rem_q[SW-2:0], ~w_trial[CW]};
                r_dk    <= r_dk + 1'b1;
            end
            // present result and rearm
            if (i_cmd.out_load) begin
                o_center_x    <= r_ctx;
                o_center_y    <= r_cty;
                o_center_z    <= w_q[19:0];
                o_extent_x    <= (w_ex < 22'sd1) ? 21'd1 : w_ex[20:0];
                o_extent_y    <= (w_ey < 22'sd1) ? 21'd1 : w_ey[20:0];
                o_extent_z    <= (w_ez < 21'sd1) ? 20'd1 : w_ez[19:0];
                o_box_heading <= r_heading;
                r_first <= 1'b1;
                r_a1min <= '0; r_a1max <= '0;
                r_a2min <= '0; r_a2max <= '0;
                r_hmin  <= '0; r_hmax  <= '0;
                r_hsum  <= '0; r_cnt   <= '0;
            end
        end
    end

    assign o_status.first       = r_first;
    assign o_status.cordic_done = (r_ci >= SIW'(CORDIC_STEPS));
    assign o_status.div_done    = (r_dk == ($clog2(SW+1))'(SW));

    `ASSERT_IMPLIES(a_cnt_cap, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MAX_POINTS))
    `ASSERT_IMPLIES(a_heading_rng, i_clk, i_rst_n, 1'b1, r_heading <= 17'(HALF_PI_Q))
    `ASSERT_IMPLIES(a_order, i_clk, i_rst_n, !r_first, r_a1min <= r_a1max)
endmodule

/* sim/tb_oriented_box_fit_core.sv */
`timescale 1ns / 1ps
module tb_oriented_box_fit_core;
    localparam int MAX_PTS    = 65536;
    localparam int ROT_STEPS  = 16;
    localparam int N_RANDOM   = 1950;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int S21_HI = 1048575;
    localparam int S21_LO = -1048576;

    typedef struct packed {
        logic        last;
        logic [18:0] heading;
        logic [19:0] z;
        logic [19:0] y;
        logic [19:0] x;
    } t_point;

    typedef struct packed {
        logic [16:0] heading;
        logic [19:0] ext_z;
        logic [20:0] ext_y;
        logic [20:0] ext_x;
        logic [19:0] cen_z;
        logic [20:0] cen_y;
        logic [20:0] cen_x;
    } t_box;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;

    oriented_box_fit_core #(.MAX_POINTS(MAX_PTS), .CORDIC_STEPS(ROT_STEPS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    t_point pending_points[$];
    t_box   expected_boxes[$];
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     mismatches = 0;
    int     boxes_seen = 0;
    int     points_sent = 0;
    longint cycles = 0;

    // fitter state
    bit     fit_first = 1'b1;
    longint fit_heading = 0, fit_cos = 0, fit_sin = 0;
    longint a1_lo, a1_hi, a2_lo, a2_hi, z_lo, z_hi, z_sum = 0, z_count = 0;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint rot_angle(int i);
        longint tbl[17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2, 1};
        return i < 17 ? tbl[i] : 0;
    endfunction

    // latch heading and rotate the unit vector to it
    task automatic fold_heading(longint h);
        longint t, cx, cy, za, dx, dy;
        if (h < 0) h += obf_pkg::PI_Q;
        t = (h > obf_pkg::HALF_PI_Q) ? (obf_pkg::PI_Q - h) : (obf_pkg::HALF_PI_Q - h);
        fit_heading = clip(t, 0, obf_pkg::HALF_PI_Q);
        cx = obf_pkg::INV_GAIN; cy = 0; za = fit_heading;
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = cy >>> i; dy = cx >>> i;
            if (za >= 0) begin
                cx -= dx; cy += dy; za -= rot_angle(i);
            end else begin
                cx += dx; cy -= dy; za += rot_angle(i);
            end
        end
        fit_cos = clip(cx, -131072, 131071);
        fit_sin = clip(cy, -131072, 131071);
    endtask

    task automatic fit_point(t_point p);
        longint px, py, pz, p1, p2, s1, s2, ex, ey, ez;
        t_box b;
        px = longint'($signed(p.x)); py = longint'($signed(p.y));
        pz = longint'($signed(p.z));
        if (fit_first) fold_heading(longint'($signed(p.heading)));
        p1 = clip((px * fit_cos + py * fit_sin + 32768) >>> 16, S21_LO, S21_HI);
        p2 = clip((py * fit_cos - px * fit_sin + 32768) >>> 16, S21_LO, S21_HI);
        if (fit_first) begin
            a1_lo = p1; a1_hi = p1; a2_lo = p2; a2_hi = p2; z_lo = pz; z_hi = pz;
            fit_first = 1'b0;
        end else begin
            if (p1 < a1_lo) a1_lo = p1;
            if (p1 > a1_hi) a1_hi = p1;
            if (p2 < a2_lo) a2_lo = p2;
            if (p2 > a2_hi) a2_hi = p2;
            if (pz < z_lo) z_lo = pz;
            if (pz > z_hi) z_hi = pz;
        end
        if (z_count < MAX_PTS) begin
            z_sum += pz; z_count++;
        end
        if (!p.last) return;
        s1 = a1_lo + a1_hi; s2 = a2_lo + a2_hi;
        b.cen_x = 21'(clip((s1 * fit_cos - s2 * fit_sin + 65536) >>> 17, S21_LO, S21_HI));
        b.cen_y = 21'(clip((s1 * fit_sin + s2 * fit_cos + 65536) >>> 17, S21_LO, S21_HI));
        b.cen_z = 20'(z_sum / (z_count > 0 ? z_count : 1));
        ex = a1_hi - a1_lo; ey = a2_hi - a2_lo; ez = z_hi - z_lo;
        b.ext_x = 21'(ex < 1 ? 1 : ex);
        b.ext_y = 21'(ey < 1 ? 1 : ey);
        b.ext_z = 20'(ez < 1 ? 1 : ez);
        b.heading = 17'(fit_heading);
        expected_boxes.insert(expected_boxes.size(), b);
        fit_first = 1'b1; z_sum = 0; z_count = 0;
    endtask

    // drive points from the queue
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                fit_point(t_point'({s_axis_tlast, s_axis_tdata[78:0]}));
                points_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_points.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    t_point p;
                    p = pending_points.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {1'b0, p.heading, p.z, p.y, p.x};
                    s_axis_tlast  <= p.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // check boxes against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                t_box got, want;
                got = m_axis_tdata[140:0];
                boxes_seen++;
                if (expected_boxes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected box %h", got);
                end else begin
                    want = expected_boxes.pop_front();
                    if (got !== want || m_axis_tdata[143:141] !== '0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("box %0d mismatch: exp %h got %h", boxes_seen,
                                     want, m_axis_tdata);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [19:0] rand_coord(int mode);
        case (mode)
            0: return 20'($urandom);
            1: return 20'($urandom_range(4000)) - 20'd2000;
            2: return ($urandom_range(1) != 0) ? 20'h7FFFF : 20'h80000;
            default: return 20'($urandom_range(200000)) - 20'd100000;
        endcase
    endfunction

    function automatic logic [18:0] rand_heading();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 19'($urandom);
        if (r == 1) return ($urandom_range(1) != 0) ? 19'(205887) : 19'(-205887);
        return 19'($urandom_range(411774) - 205887);
    endfunction

    task automatic add_point(logic [19:0] x, y, z, logic [18:0] h, bit last);
        t_point p;
        p.x = x; p.y = y; p.z = z; p.heading = h; p.last = last;
        pending_points.insert(pending_points.size(), p);
    endtask

    task automatic add_cluster(int n);
        int mode;
        mode = $urandom_range(3);
        for (int i = 0; i < n; i++)
            add_point(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                      rand_heading(), i == n - 1);
    endtask

    task automatic drain();
        while (pending_points.size() > 0 || s_axis_tvalid || expected_boxes.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int phase_idle[4];
        int phase_stall[4];
        int queued;
        phase_idle = '{0, 76, 0, 31};
        phase_stall = '{0, 0, 76, 31};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, every heading region, single point clusters
        add_point(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 19'(205887), 1'b1);
        add_point(20'h80000, 20'h80000, 20'h80000, 19'(-205887), 1'b1);
        add_point(20'h7FFFF, 20'h80000, 20'h7FFFF, 19'd0, 1'b0);
        add_point(20'h80000, 20'h7FFFF, 20'h80000, 19'd0, 1'b1);
        add_point(20'd1000, 20'd2000, 20'd0, 19'(102944), 1'b0);
        add_point(20'd1000, 20'd2000, 20'd0, 19'd5, 1'b1);
        add_point(20'd5, 20'd5, 20'd5, 19'(102945), 1'b1);
        add_point(20'd5, 20'd5, 20'd5, 19'(-102944), 1'b1);
        add_point(20'd5, 20'd5, 20'd5, 19'h40000, 1'b1);
        add_point(20'd5, 20'd5, 20'd5, 19'h3FFFF, 1'b1);
        add_point(-20'd7, 20'd3, -20'd1, 19'(-1), 1'b0);
        add_point(20'd7, -20'd3, -20'd2, 19'd1, 1'b0);
        add_point(20'd0, 20'd0, -20'd4, 19'd1, 1'b1);
        drain();

        // random clusters under each idling mix
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = phase_idle[ph];
            recv_stall_pct = phase_stall[ph];
            queued = 0;
            while (queued < N_RANDOM / 4) begin
                int n;
                n = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
                add_cluster(n);
                queued += n;
            end
            drain();
        end
        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (100) @(posedge i_clk);
        $display("Sent %0d points, checked %0d boxes over four handshake mixes.",
                 points_sent, boxes_seen);
        if (mismatches == 0 && expected_boxes.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d boxes missing", mismatches,
                     expected_boxes.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

    // end the run if it hangs
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/obf_pkg.sv
rtl/obf_ctrl.sv
rtl/obf_dp.sv
rtl/oriented_box_fit_core.sv
sim/tb_oriented_box_fit_core.sv
